FILE: sv/mh64_pkg.sv
// ----------------------------------------------------------------------------
// mh64_pkg: shared types and constants of the MurmurHash64A key hasher
// Mixing constants, item and control structs, and the back-end state codes.
// ----------------------------------------------------------------------------
package mh64_pkg;

	localparam logic [63:0] MUL_M         = 64'hc6a4_a793_5bd1_e995;
	localparam int          SHIFT_R       = 47;
	localparam int          ADDR_BITS     = 48;
	localparam int          TAG_BITS      = 14;
	localparam int          KLEN_BITS     = 13;
	localparam int          CNT_BITS      = 4;
	localparam int          MAX_KEY_BYTES = 4096;
	localparam int          CNT_MAX       = 8191;
	localparam int          WORD_BYTES    = 8;
	localparam int          FIFO_DEPTH    = 2;
	localparam logic [63:0] SEED_RESET    = 64'd151261303;
	localparam logic [5:0]  TSL2_RESET    = 6'd20;

	// classified key word as queued between front and back
	typedef struct packed {
		logic [63:0]           word;        // full word, or tail with high bytes cleared
		logic [CNT_BITS-1:0]   cnt;         // clamped to 0..8
		logic                  first;
		logic                  last;
		logic [KLEN_BITS-1:0]  klen;
		logic                  full;        // eight bytes: mix path
		logic                  tail_nz;     // 1..7 bytes: tail fold path
		logic                  set_partial; // marks a length error
	} item_t;

	typedef struct packed {
		logic [63:0] seed;
		logic [5:0]  tsl2;
	} cfg_t;

	typedef struct packed {
		logic not_empty;
		logic full;
	} fifo_stat_t;

	typedef struct packed {
		logic pop;
		logic emit;
	} back_stat_t;

	typedef enum logic [2:0] {
		BS_IDLE,
		BS_INIT,
		BS_DISP,
		BS_K1,
		BS_K2,
		BS_H,
		BS_FIN
	} back_state_t;

	// partial products of a 64x64 low-half multiply
	typedef enum logic [1:0] {
		MS_LL,
		MS_LH,
		MS_HL
	} mul_step_t;

endpackage

FILE: sv/mh64_if.sv
// ----------------------------------------------------------------------------
// mh64_if: stream channels of the key hasher
// Key word channel and hash result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mh64_in_if;
	logic                           valid;
	logic                           ready;
	logic [63:0]                    key_word;
	logic [mh64_pkg::CNT_BITS-1:0]  byte_count;
	logic                           first_word;
	logic                           last_word;
	logic [mh64_pkg::KLEN_BITS-1:0] key_length;

	modport source (output valid, key_word, byte_count, first_word, last_word, key_length,
		input ready);
	modport sink (input valid, key_word, byte_count, first_word, last_word, key_length,
		output ready);
endinterface

interface mh64_out_if;
	logic                           valid;
	logic                           ready;
	logic [63:0]                    hash_value;
	logic [mh64_pkg::ADDR_BITS-1:0] bucket_index;
	logic [mh64_pkg::TAG_BITS-1:0]  tag;
	logic                           length_error;

	modport source (output valid, hash_value, bucket_index, tag, length_error, input ready);
	modport sink (input valid, hash_value, bucket_index, tag, length_error, output ready);
endinterface

FILE: sv/mh64_front.sv
// ----------------------------------------------------------------------------
// mh64_front: key word intake
// Accepts key words, clamps the byte count, masks the tail and picks the path.
// ----------------------------------------------------------------------------
module mh64_front (
	mh64_in_if.sink              in_ch,
	input  mh64_pkg::fifo_stat_t fifo_stat,
	output logic                 push,
	output mh64_pkg::item_t      item
);

	logic [mh64_pkg::CNT_BITS-1:0] cnt;
	logic                          over;
	logic [63:0]                   tail;

	assign in_ch.ready = !fifo_stat.full;
	assign push        = in_ch.valid && !fifo_stat.full;

	assign over = in_ch.byte_count > mh64_pkg::CNT_BITS'(mh64_pkg::WORD_BYTES);
	assign cnt  = over ? mh64_pkg::CNT_BITS'(mh64_pkg::WORD_BYTES) : in_ch.byte_count;

	always_comb begin
		for (int i = 0; i < mh64_pkg::WORD_BYTES; i++) begin
			tail[8*i +: 8] = (mh64_pkg::CNT_BITS'(i) < cnt) ? in_ch.key_word[8*i +: 8] : 8'h00;
		end
	end

	always_comb begin
		item.word    = tail;
		item.cnt     = cnt;
		item.first   = in_ch.first_word;
		item.last    = in_ch.last_word;
		item.klen    = in_ch.key_length;
		item.full    = cnt == mh64_pkg::CNT_BITS'(mh64_pkg::WORD_BYTES);
		item.tail_nz = !item.full && cnt != '0;
		// oversized count, or a short word before the end
		item.set_partial = over || (!item.full && !in_ch.last_word);
	end

endmodule

FILE: sv/mh64_fifo.sv
// ----------------------------------------------------------------------------
// mh64_fifo: item queue between front and back
// Short register queue of classified key words.
// ----------------------------------------------------------------------------
module mh64_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  mh64_pkg::item_t      push_item,
	input  logic                 pop,
	output mh64_pkg::item_t      head,
	output mh64_pkg::fifo_stat_t stat
);

	localparam int PW = (mh64_pkg::FIFO_DEPTH > 1) ? $clog2(mh64_pkg::FIFO_DEPTH) : 1;
	localparam int CW = $clog2(mh64_pkg::FIFO_DEPTH + 1);

	mh64_pkg::item_t mem_q [mh64_pkg::FIFO_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(mh64_pkg::FIFO_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign stat.not_empty = count_q != '0;
	assign stat.full      = count_q == CW'(mh64_pkg::FIFO_DEPTH);
	assign head           = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

FILE: sv/mh64_back.sv
// ----------------------------------------------------------------------------
// mh64_back: hash engine
// Sequences the MurmurHash64A steps over one shared 32x32 multiplier and
// holds the result in an output register.
// ----------------------------------------------------------------------------
module mh64_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mh64_pkg::cfg_t       cfg,
	input  mh64_pkg::fifo_stat_t fifo_stat,
	input  mh64_pkg::item_t      head,
	output mh64_pkg::back_stat_t stat,
	mh64_out_if.source           out_ch
);

	localparam int KW = mh64_pkg::KLEN_BITS;

	mh64_pkg::back_state_t st_q, st_d;
	mh64_pkg::mul_step_t   step_q;
	mh64_pkg::item_t       work_q;

	logic [63:0]  h_q;
	logic [63:0]  opnd_q;
	logic [63:0]  acc_q;
	logic [KW-1:0] bytes_q;
	logic [KW-1:0] exp_q;
	logic          partial_q;

	logic          out_valid_q;
	logic [63:0]   out_hash_q;
	logic [mh64_pkg::ADDR_BITS-1:0] out_bucket_q;
	logic [mh64_pkg::TAG_BITS-1:0]  out_tag_q;
	logic          out_err_q;

	logic          in_mul;
	logic          mul_last;
	logic          stall;
	logic          mul_en;
	logic [31:0]   mx;
	logic [31:0]   my;
	logic [63:0]   prod;
	logic [63:0]   mul_res;
	logic [63:0]   fin_hash;
	logic [5:0]    bits;
	logic [mh64_pkg::ADDR_BITS-1:0] idx_mask;
	logic [KW:0]   byte_sum;
	logic [KW-1:0] byte_sat;
	logic [KW-1:0] byte_base;

	// shared multiplier: low 64 bits of opnd * M from three 32x32 products
	always_comb begin
		unique case (step_q)
			mh64_pkg::MS_LL: begin
				mx = opnd_q[31:0];
				my = mh64_pkg::MUL_M[31:0];
			end
			mh64_pkg::MS_LH: begin
				mx = opnd_q[31:0];
				my = mh64_pkg::MUL_M[63:32];
			end
			mh64_pkg::MS_HL: begin
				mx = opnd_q[63:32];
				my = mh64_pkg::MUL_M[31:0];
			end
			default: begin
				mx = '0;
				my = '0;
			end
		endcase
	end

	assign prod     = mx * my;
	assign mul_res  = acc_q + {prod[31:0], 32'h0};
	assign fin_hash = mul_res ^ (mul_res >> mh64_pkg::SHIFT_R);

	assign in_mul   = st_q == mh64_pkg::BS_INIT || st_q == mh64_pkg::BS_K1 ||
		st_q == mh64_pkg::BS_K2 || st_q == mh64_pkg::BS_H || st_q == mh64_pkg::BS_FIN;
	assign mul_last = step_q == mh64_pkg::MS_HL;
	assign stall    = st_q == mh64_pkg::BS_FIN && out_valid_q && !out_ch.ready;

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			mh64_pkg::BS_IDLE: begin
				if (fifo_stat.not_empty) begin
					st_d = head.first ? mh64_pkg::BS_INIT : mh64_pkg::BS_DISP;
				end
			end
			mh64_pkg::BS_INIT: begin
				if (mul_last) st_d = mh64_pkg::BS_DISP;
			end
			mh64_pkg::BS_DISP: begin
				priority if (work_q.full) st_d = mh64_pkg::BS_K1;
				else if (work_q.tail_nz) st_d = mh64_pkg::BS_H;
				else if (work_q.last) st_d = mh64_pkg::BS_FIN;
				else st_d = mh64_pkg::BS_IDLE;
			end
			mh64_pkg::BS_K1: begin
				if (mul_last) st_d = mh64_pkg::BS_K2;
			end
			mh64_pkg::BS_K2: begin
				if (mul_last) st_d = mh64_pkg::BS_H;
			end
			mh64_pkg::BS_H: begin
				if (mul_last) st_d = work_q.last ? mh64_pkg::BS_FIN : mh64_pkg::BS_IDLE;
			end
			mh64_pkg::BS_FIN: begin
				if (mul_last && !stall) st_d = mh64_pkg::BS_IDLE;
			end
			default: st_d = mh64_pkg::BS_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		stat.pop  = st_q == mh64_pkg::BS_IDLE && fifo_stat.not_empty;
		stat.emit = st_q == mh64_pkg::BS_FIN && mul_last && !stall;
		mul_en    = in_mul && !stall;
	end

	assign bits     = (cfg.tsl2 > 6'(mh64_pkg::ADDR_BITS)) ? 6'(mh64_pkg::ADDR_BITS) : cfg.tsl2;
	assign idx_mask = ~({mh64_pkg::ADDR_BITS{1'b1}} << bits);

	assign byte_base = head.first ? '0 : bytes_q;
	assign byte_sum  = {1'b0, byte_base} + (KW+1)'(head.cnt);
	assign byte_sat  = (byte_sum > (KW+1)'(mh64_pkg::CNT_MAX)) ? KW'(mh64_pkg::CNT_MAX)
		: byte_sum[KW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= mh64_pkg::BS_IDLE;
			step_q <= mh64_pkg::MS_LL;
		end else begin
			st_q <= st_d;
			if (mul_en) begin
				unique case (step_q)
					mh64_pkg::MS_LL: step_q <= mh64_pkg::MS_LH;
					mh64_pkg::MS_LH: step_q <= mh64_pkg::MS_HL;
					default:         step_q <= mh64_pkg::MS_LL;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stat.pop) begin
			work_q <= head;
		end
		if (mul_en) begin
			if (step_q == mh64_pkg::MS_LL) begin
				acc_q <= prod;
			end else begin
				acc_q <= mul_res;
			end
		end
		if (st_q == mh64_pkg::BS_IDLE) begin
			opnd_q <= 64'(head.klen);
		end else if (st_q == mh64_pkg::BS_DISP) begin
			priority if (work_q.full) opnd_q <= work_q.word;
			else if (work_q.tail_nz) opnd_q <= h_q ^ work_q.word;
			else opnd_q <= h_q ^ (h_q >> mh64_pkg::SHIFT_R);
		end else if (mul_last && mul_en) begin
			unique case (st_q)
				mh64_pkg::BS_K1: opnd_q <= fin_hash;
				mh64_pkg::BS_K2: opnd_q <= h_q ^ mul_res;
				mh64_pkg::BS_H:  opnd_q <= fin_hash;
				default:         opnd_q <= opnd_q;
			endcase
		end
	end

	// key state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q       <= '0;
			bytes_q   <= '0;
			exp_q     <= '0;
			partial_q <= 1'b0;
		end else begin
			if (stat.pop) begin
				bytes_q   <= byte_sat;
				partial_q <= (head.first ? 1'b0 : partial_q) | head.set_partial;
				if (head.first) exp_q <= head.klen;
			end
			if (stat.emit) begin
				h_q       <= '0;
				bytes_q   <= '0;
				exp_q     <= '0;
				partial_q <= 1'b0;
			end else if (mul_last && mul_en) begin
				unique case (st_q)
					mh64_pkg::BS_INIT: h_q <= cfg.seed ^ mul_res;
					mh64_pkg::BS_K2:   h_q <= h_q ^ mul_res;
					mh64_pkg::BS_H:    h_q <= mul_res;
					default:           h_q <= h_q;
				endcase
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.emit) begin
			out_hash_q   <= fin_hash;
			out_bucket_q <= fin_hash[mh64_pkg::ADDR_BITS-1:0] & idx_mask;
			out_tag_q    <= fin_hash[mh64_pkg::ADDR_BITS +: mh64_pkg::TAG_BITS];
			out_err_q    <= partial_q || bytes_q != exp_q ||
				32'(exp_q) > mh64_pkg::MAX_KEY_BYTES;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.hash_value   = out_hash_q;
	assign out_ch.bucket_index = out_bucket_q;
	assign out_ch.tag          = out_tag_q;
	assign out_ch.length_error = out_err_q;

endmodule

FILE: sv/murmur64a_key_hasher.sv
// ----------------------------------------------------------------------------
// murmur64a_key_hasher: streaming MurmurHash64A of keys with bucket and tag
// Front classifies key words, a two-entry queue decouples it from the hash
// engine, which emits hash, bucket index and tag on the last word of a key.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake        payload
//  key_in    in   valid/ready      key_word, byte_count, first_word, last_word, key_length
//  hash_out  out  valid/ready      hash_value, bucket_index, tag, length_error
//  apb       in   psel/penable     paddr 0: hash_seed, paddr 8: table_size_log2
//
// Full, tail and empty words take different paths through the engine; a first
// word adds the seed initialization, a last word adds finalization. Each 64-bit
// multiply runs on the one shared 32x32 multiplier.
// Reset clears key state; the seed and table size return to 151261303 and 20.
// key_in stalls only when the queue is full; a held result stalls the engine
// at finalization while the queue keeps taking words.
//
module murmur64a_key_hasher (
	input  logic        clk,
	input  logic        arst_n,
	mh64_in_if.sink     key_in,
	mh64_out_if.source  hash_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	mh64_pkg::cfg_t       cfg_q;
	mh64_pkg::fifo_stat_t fifo_stat;
	mh64_pkg::back_stat_t back_stat;
	mh64_pkg::item_t      push_item;
	mh64_pkg::item_t      head;
	logic                 push;
	logic                 cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = paddr[3] ? {58'h0, cfg_q.tsl2} : cfg_q.seed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.seed <= mh64_pkg::SEED_RESET;
			cfg_q.tsl2 <= mh64_pkg::TSL2_RESET;
		end else if (cfg_wr) begin
			if (paddr[3]) begin
				cfg_q.tsl2 <= pwdata[5:0];
			end else begin
				cfg_q.seed <= pwdata;
			end
		end
	end

	mh64_front u_front (
		.in_ch     (key_in),
		.fifo_stat (fifo_stat),
		.push      (push),
		.item      (push_item)
	);

	mh64_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (back_stat.pop),
		.head      (head),
		.stat      (fifo_stat)
	);

	mh64_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.fifo_stat (fifo_stat),
		.head      (head),
		.stat      (back_stat),
		.out_ch    (hash_out)
	);

	a_pop_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.pop |-> fifo_stat.not_empty)
		else $error("engine popped an empty queue");

	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.emit |=> hash_out.valid)
		else $error("emitted result not presented");

	a_emit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.emit |-> (!hash_out.valid || hash_out.ready))
		else $error("result overwritten while held");

	a_tsl2_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr && paddr[3]) |=> cfg_q.tsl2 == $past(pwdata[5:0]))
		else $error("table size write lost");

endmodule
